// ===== hw/rtl/wsfd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsfd_pkg
// Shared types and constants for the websocket frame deframer.
// ----------------------------------------------------------------------------
package wsfd_pkg;

  // parser phase
  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_MASK = 3'd3,
    PH_PAY  = 3'd4,
    PH_STOP = 3'd5
  } phase_t;

  // event kinds on the result channel
  localparam logic [1:0] EV_DATA    = 2'd0;
  localparam logic [1:0] EV_PING    = 2'd1;
  localparam logic [1:0] EV_CLOSE   = 2'd2;
  localparam logic [1:0] EV_LEN_ERR = 2'd3;

  // frame opcodes
  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;

  // message types
  localparam logic [1:0] MT_NONE   = 2'd0;
  localparam logic [1:0] MT_TEXT   = 2'd1;
  localparam logic [1:0] MT_BINARY = 2'd2;

  // short length codes for extended forms
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [31:0] MAX_LEN_RESET = 32'd5242880;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] data;
    logic       has;
    logic [1:0] mtype;
    logic       last;
  } result_t;

endpackage

// ===== hw/rtl/websocket_frame_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit
// WebSocket receive deframer: header parsing, unmasking, message streaming.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle on rx_byte unless out_ready stalls a result,
// and streams out unmasked payload bytes with message type and last flag,
// ping payload for pong, and close and length error events. Every byte goes
// through an input register and then the parser into the result register, so
// a byte may be accepted every cycle; the rate is set only by out_ready.
// After a close or a length error the unit swallows all input until reset.
// max_payload_len (cfg_data) limits the 64-bit length form only; cfg_ready is
// always high. The user must write the limit while the unit is idle; the unit does not enforce it.
module websocket_frame_deframer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  event_kind,
  output logic [7:0]  data_byte,
  output logic        has_data,
  output logic [1:0]  message_type,
  output logic        last
);
  import wsfd_pkg::*;

  logic [31:0] max_len;
  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        advance;
  logic        step;
  result_t     res;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || out_ready;
  assign in_ready  = !s1_valid || advance;
  assign step      = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (cfg_valid) begin
      max_len <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_byte <= rx_byte;
  end

  wsfd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .byte_in (s1_byte),
    .max_len (max_len),
    .res     (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      event_kind   <= res.kind;
      data_byte    <= res.data;
      has_data     <= res.has;
      message_type <= res.mtype;
      last         <= res.last;
    end
  end

  a_event_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind == EV_CLOSE || event_kind == EV_LEN_ERR)
      |-> !has_data && !last && message_type == MT_NONE)
    else $error("close or length error word carries data");

  a_data_type: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == EV_DATA
      |-> message_type == MT_TEXT || message_type == MT_BINARY)
    else $error("message word without text or binary type");

  a_quiet_after_stop: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && (event_kind == EV_CLOSE || event_kind == EV_LEN_ERR)
      |=> !out_valid)
    else $error("word delivered after close or length error");

endmodule

// ===== hw/rtl/wsfd_parser.sv =====
// ----------------------------------------------------------------------------
// wsfd_parser
// Frame header parser, payload unmasking and fragment tracking, one byte a step.
// ----------------------------------------------------------------------------
module wsfd_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        byte_in,
  input  logic [31:0]       max_len,
  output wsfd_pkg::result_t res
);
  import wsfd_pkg::*;

  phase_t      phase, phase_next;
  logic        frame_fin, frame_fin_next;
  logic [3:0]  frame_opcode, frame_opcode_next;
  logic        frame_masked, frame_masked_next;
  logic [2:0]  ext_left, ext_left_next;
  logic [63:0] remaining, remaining_next;
  logic [31:0] mask_key, mask_key_next;
  logic [1:0]  mask_index, mask_index_next;
  logic        frag_open, frag_open_next;
  logic [1:0]  frag_type, frag_type_next;
  logic        ext_long, ext_long_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HDR0;
      frame_fin    <= 1'b0;
      frame_opcode <= OP_CONT;
      frame_masked <= 1'b0;
      ext_left     <= 3'd0;
      remaining    <= 64'd0;
      mask_key     <= 32'd0;
      mask_index   <= 2'd0;
      frag_open    <= 1'b0;
      frag_type    <= MT_NONE;
      ext_long     <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      frame_fin    <= frame_fin_next;
      frame_opcode <= frame_opcode_next;
      frame_masked <= frame_masked_next;
      ext_left     <= ext_left_next;
      remaining    <= remaining_next;
      mask_key     <= mask_key_next;
      mask_index   <= mask_index_next;
      frag_open    <= frag_open_next;
      frag_type    <= frag_type_next;
      ext_long     <= ext_long_next;
    end
  end

  logic        len_done;
  logic        hdr_done;
  logic        len_zero;
  logic [6:0]  len7;
  logic [63:0] rem_shift;
  logic [7:0]  key;
  logic [7:0]  unmasked;
  logic        pay_end;

  always_comb begin
    phase_next        = phase;
    frame_fin_next    = frame_fin;
    frame_opcode_next = frame_opcode;
    frame_masked_next = frame_masked;
    ext_left_next     = ext_left;
    remaining_next    = remaining;
    mask_key_next     = mask_key;
    mask_index_next   = mask_index;
    frag_open_next    = frag_open;
    frag_type_next    = frag_type;
    ext_long_next     = ext_long;
    res               = '0;
    len_done          = 1'b0;
    hdr_done          = 1'b0;
    len_zero          = 1'b0;
    len7              = byte_in[6:0];
    rem_shift         = {remaining[55:0], byte_in};
    key               = frame_masked ? mask_key[8*(3 - mask_index) +: 8] : 8'd0;
    unmasked          = byte_in ^ key;
    pay_end           = (remaining == 64'd1);

    case (phase)
      PH_HDR0: begin
        frame_fin_next    = byte_in[7];
        frame_opcode_next = byte_in[3:0];
        phase_next        = PH_HDR1;
      end
      PH_HDR1: begin
        frame_masked_next = byte_in[7];
        if (len7 == LEN_EXT16 || len7 == LEN_EXT64) begin
          ext_long_next  = (len7 == LEN_EXT64);
          ext_left_next  = (len7 == LEN_EXT64) ? 3'd7 : 3'd1;
          remaining_next = 64'd0;
          phase_next     = PH_EXT;
        end else begin
          remaining_next = {57'd0, len7};
          len_zero       = (len7 == 7'd0);
          len_done       = 1'b1;
        end
      end
      PH_EXT: begin
        remaining_next = rem_shift;
        if (ext_left != 3'd0) begin
          ext_left_next = ext_left - 3'd1;
        end else if (ext_long && (rem_shift[63:32] != 32'd0 ||
                                  rem_shift[31:0] > max_len)) begin
          phase_next = PH_STOP;
          res.valid  = 1'b1;
          res.kind   = EV_LEN_ERR;
        end else begin
          len_zero = (rem_shift == 64'd0);
          len_done = 1'b1;
        end
      end
      PH_MASK: begin
        mask_key_next = {mask_key[23:0], byte_in};
        if (mask_index == 2'd3) begin
          len_zero = (remaining == 64'd0);
          hdr_done = 1'b1;
        end else begin
          mask_index_next = mask_index + 2'd1;
        end
      end
      PH_PAY: begin
        mask_index_next = mask_index + 2'd1;
        remaining_next  = remaining - 64'd1;
        if (pay_end) phase_next = PH_HDR0;
        case (frame_opcode)
          OP_TEXT, OP_BINARY: begin
            res.valid = 1'b1;
            res.kind  = EV_DATA;
            res.data  = unmasked;
            res.has   = 1'b1;
            res.mtype = frame_opcode[1:0];
            res.last  = frame_fin && pay_end;
          end
          OP_CONT: begin
            if (frag_open) begin
              if (pay_end && frame_fin) frag_open_next = 1'b0;
              res.valid = 1'b1;
              res.kind  = EV_DATA;
              res.data  = unmasked;
              res.has   = 1'b1;
              res.mtype = frag_type;
              res.last  = frame_fin && pay_end;
            end
          end
          OP_PING: begin
            res.valid = 1'b1;
            res.kind  = EV_PING;
            res.data  = unmasked;
            res.has   = 1'b1;
            res.last  = pay_end;
          end
          OP_CLOSE: begin
            if (pay_end) begin
              phase_next = PH_STOP;
              res.valid  = 1'b1;
              res.kind   = EV_CLOSE;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    // length known: collect the mask key or finish the header
    if (len_done) begin
      if (frame_masked_next) begin
        phase_next      = PH_MASK;
        mask_index_next = 2'd0;
      end else begin
        hdr_done = 1'b1;
      end
    end

    if (hdr_done) begin
      if ((frame_opcode == OP_TEXT || frame_opcode == OP_BINARY) && !frame_fin) begin
        frag_open_next = 1'b1;
        frag_type_next = frame_opcode[1:0];
      end
      mask_index_next = 2'd0;
      if (!len_zero) begin
        phase_next = PH_PAY;
      end else begin
        // empty frame: marker result only
        phase_next = PH_HDR0;
        case (frame_opcode)
          OP_TEXT, OP_BINARY: begin
            res.valid = 1'b1;
            res.kind  = EV_DATA;
            res.mtype = frame_opcode[1:0];
            res.last  = frame_fin;
          end
          OP_CONT: begin
            if (frag_open) begin
              if (frame_fin) frag_open_next = 1'b0;
              res.valid = 1'b1;
              res.kind  = EV_DATA;
              res.mtype = frag_type;
              res.last  = frame_fin;
            end
          end
          OP_PING: begin
            res.valid = 1'b1;
            res.kind  = EV_PING;
            res.last  = 1'b1;
          end
          OP_CLOSE: begin
            phase_next = PH_STOP;
            res.valid  = 1'b1;
            res.kind   = EV_CLOSE;
          end
          default: ;
        endcase
      end
    end
  end

  a_stop_sticks: assert property (@(posedge clk) disable iff (rst)
    phase == PH_STOP |=> phase == PH_STOP)
    else $error("parser left the stopped phase");

  a_pay_starts_key: assert property (@(posedge clk) disable iff (rst)
    step && phase != PH_PAY && phase_next == PH_PAY |-> mask_index_next == 2'd0)
    else $error("payload entered with mask index not at zero");

endmodule

// ===== tb/deframer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deframer_checker
// Watches the byte, config and result channels of the websocket deframer,
// predicts every result word from the accepted bytes and compares in order.
// ----------------------------------------------------------------------------
module deframer_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  event_kind,
  input  logic [7:0]  data_byte,
  input  logic        has_data,
  input  logic [1:0]  message_type,
  input  logic        last,
  output int          fail_count,
  output int          words_pending
);
  import wsfd_pkg::*;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       has;
    logic [1:0] mtype;
    logic       last;
  } word_t;

  word_t       expected_q[$];

  // parser copy
  phase_t      phase;
  logic        fin;
  logic        masked;
  logic        ext_long;
  logic        run_open;
  logic [3:0]  opcode;
  logic [2:0]  ext_left;
  logic [63:0] remaining;
  logic [31:0] key;
  logic [31:0] limit;
  logic [1:0]  key_idx;
  logic [1:0]  run_type;

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= 40) begin
      $display("%0t ns deframer mismatch: %s", $time, what);
    end
  endtask

  task automatic expect_word(input logic [1:0] kind, input logic [7:0] data,
                             input logic has, input logic [1:0] mtype, input logic lst);
    word_t w;
    w.kind  = kind;
    w.data  = data;
    w.has   = has;
    w.mtype = mtype;
    w.last  = lst;
    expected_q.insert(expected_q.size(), w);
  endtask

  // header complete: run bookkeeping, then payload or the empty-frame word
  task automatic finish_header();
    if ((opcode == OP_TEXT || opcode == OP_BINARY) && !fin) begin
      run_open = 1'b1;
      run_type = opcode[1:0];
    end
    key_idx = '0;
    if (remaining != 0) begin
      phase = PH_PAY;
    end else begin
      phase = PH_HDR0;
      case (opcode)
        OP_TEXT, OP_BINARY: expect_word(EV_DATA, 8'h00, 1'b0, opcode[1:0], fin);
        OP_CONT: begin
          if (run_open) begin
            expect_word(EV_DATA, 8'h00, 1'b0, run_type, fin);
            if (fin) run_open = 1'b0;
          end
        end
        OP_PING: expect_word(EV_PING, 8'h00, 1'b0, MT_NONE, 1'b1);
        OP_CLOSE: begin
          phase = PH_STOP;
          expect_word(EV_CLOSE, 8'h00, 1'b0, MT_NONE, 1'b0);
        end
        default: ;
      endcase
    end
  endtask

  task automatic finish_length();
    if (masked) begin
      phase   = PH_MASK;
      key_idx = '0;
    end else begin
      finish_header();
    end
  endtask

  task automatic parse_byte(input logic [7:0] b);
    logic [31:0] rot;
    logic [7:0]  d;
    logic        ends;
    case (phase)
      PH_HDR0: begin
        fin    = b[7];
        opcode = b[3:0];
        phase  = PH_HDR1;
      end
      PH_HDR1: begin
        masked    = b[7];
        remaining = '0;
        if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64) begin
          ext_long = (b[6:0] == LEN_EXT64);
          ext_left = ext_long ? 3'd7 : 3'd1;
          phase    = PH_EXT;
        end else begin
          remaining = 64'(b[6:0]);
          finish_length();
        end
      end
      PH_EXT: begin
        remaining = {remaining[55:0], b};
        if (ext_left != 0) begin
          ext_left = ext_left - 3'd1;
        end else if (ext_long && remaining > 64'(limit)) begin
          phase = PH_STOP;
          expect_word(EV_LEN_ERR, 8'h00, 1'b0, MT_NONE, 1'b0);
        end else begin
          finish_length();
        end
      end
      PH_MASK: begin
        key = {key[23:0], b};
        if (key_idx == 2'd3) finish_header();
        else key_idx = key_idx + 2'd1;
      end
      PH_PAY: begin
        // key bytes go out first byte first
        rot       = key << {key_idx, 3'b000};
        d         = masked ? (b ^ rot[31:24]) : b;
        key_idx   = key_idx + 2'd1;
        remaining = remaining - 64'd1;
        ends      = (remaining == 0);
        if (ends) phase = PH_HDR0;
        case (opcode)
          OP_TEXT, OP_BINARY: expect_word(EV_DATA, d, 1'b1, opcode[1:0], fin && ends);
          OP_CONT: begin
            if (run_open) begin
              expect_word(EV_DATA, d, 1'b1, run_type, fin && ends);
              if (fin && ends) run_open = 1'b0;
            end
          end
          OP_PING: expect_word(EV_PING, d, 1'b1, MT_NONE, ends);
          OP_CLOSE: begin
            if (ends) begin
              phase = PH_STOP;
              expect_word(EV_CLOSE, 8'h00, 1'b0, MT_NONE, 1'b0);
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  endtask

  task automatic check_word();
    word_t want;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("unexpected word kind=%0d data=%02h has=%0b type=%0d last=%0b",
                                event_kind, data_byte, has_data, message_type, last));
    end else begin
      want = expected_q.pop_front();
      if (event_kind !== want.kind || data_byte !== want.data || has_data !== want.has ||
          message_type !== want.mtype || last !== want.last) begin
        report_mismatch($sformatf(
          "got kind=%0d data=%02h has=%0b type=%0d last=%0b, want %0d %02h %0b %0d %0b",
          event_kind, data_byte, has_data, message_type, last,
          want.kind, want.data, want.has, want.mtype, want.last));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_q.delete();
      phase     = PH_HDR0;
      fin       = 1'b0;
      masked    = 1'b0;
      ext_long  = 1'b0;
      run_open  = 1'b0;
      opcode    = '0;
      ext_left  = '0;
      remaining = '0;
      key       = '0;
      key_idx   = '0;
      run_type  = '0;
      limit     = MAX_LEN_RESET;
    end else begin
      // a result never comes from the byte taken at the same edge
      if (out_valid && out_ready) check_word();
      if (cfg_valid && cfg_ready) limit = cfg_data;
      if (in_valid && in_ready) parse_byte(rx_byte);
    end
    words_pending <= expected_q.size();
  end

endmodule

// ===== tb/tb_websocket_frame_deframer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_websocket_frame_deframer_unit
// Feeds whole websocket frames byte by byte under bursty input and a stalling
// receiver, across several length limits, and ends with a close or a length
// error; the checker beside the unit predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_websocket_frame_deframer_unit;
  import wsfd_pkg::*;

  localparam int FORM_SHORT = 0;
  localparam int FORM_16    = 1;
  localparam int FORM_64    = 2;

  localparam logic [3:0] OP_RSVD_TOP = 4'hF;

  localparam int READY_ALWAYS = 0;
  localparam int READY_HALF   = 1;
  localparam int READY_SPARSE = 2;
  localparam int READY_MOSTLY = 3;

  localparam int PHASE_BYTES = 320;
  localparam int NUM_PHASES  = 5;

  logic        clk;
  logic        rst       = 1'b1;
  logic        cfg_valid = 1'b0;
  logic [31:0] cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic [7:0]  rx_byte   = '0;
  logic        out_ready = 1'b0;

  logic        cfg_ready;
  logic        in_ready;
  logic        out_valid;
  logic [1:0]  event_kind;
  logic [7:0]  data_byte;
  logic        has_data;
  logic [1:0]  message_type;
  logic        last;

  int          fail_count;
  int          words_pending;
  int          burst_left = 0;
  int          bytes_sent = 0;
  int          ready_mode = READY_ALWAYS;
  int          ready_span = 0;
  logic [31:0] cur_limit  = MAX_LEN_RESET;

  websocket_frame_deframer_unit uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_kind   (event_kind),
    .data_byte    (data_byte),
    .has_data     (has_data),
    .message_type (message_type),
    .last         (last)
  );

  deframer_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .event_kind    (event_kind),
    .data_byte     (data_byte),
    .has_data      (has_data),
    .message_type  (message_type),
    .last          (last),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_websocket_frame_deframer_unit: FAIL");
    $finish;
  end

  // receiver: changes its stall pattern after each random span
  always @(posedge clk) begin
    if (ready_span == 0) begin
      ready_mode <= $urandom_range(READY_ALWAYS, READY_MOSTLY);
      ready_span <= $urandom_range(8, 80);
    end else begin
      ready_span <= ready_span - 1;
    end
    case (ready_mode)
      READY_ALWAYS: out_ready <= 1'b1;
      READY_HALF:   out_ready <= ($urandom_range(0, 1) == 1);
      READY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:      out_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // one word on the byte channel, with a random gap between bursts
  task automatic send_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    rx_byte  <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
  endtask

  task automatic write_limit(input logic [31:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_limit = v;
  endtask

  task automatic send_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                            input logic masked, input int form, input logic [63:0] len,
                            input logic with_body);
    logic [31:0] key;
    logic [63:0] sent;
    key  = $urandom;
    sent = '0;
    send_byte({fin, rsv, op});
    case (form)
      FORM_16: begin
        send_byte({masked, LEN_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      FORM_64: begin
        send_byte({masked, LEN_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(len[i*8 +: 8]);
      end
      default: send_byte({masked, len[6:0]});
    endcase
    if (masked) begin
      for (int i = 3; i >= 0; i--) send_byte(key[i*8 +: 8]);
    end
    while (with_body && sent < len) begin
      send_byte(8'($urandom));
      sent++;
    end
  endtask

  task automatic random_frame();
    int          pick;
    int          form;
    logic [3:0]  op;
    logic [63:0] n;
    pick = $urandom_range(0, 99);
    if (pick < 20) op = OP_TEXT;
    else if (pick < 40) op = OP_BINARY;
    else if (pick < 65) op = OP_CONT;
    else if (pick < 80) op = OP_PING;
    else begin
      do op = 4'($urandom);
      while (op == OP_CONT || op == OP_TEXT || op == OP_BINARY ||
             op == OP_CLOSE || op == OP_PING);
    end
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      form = FORM_SHORT;
      n    = 64'($urandom_range(0, 8));
    end else if (pick < 75) begin
      form = FORM_SHORT;
      n    = 64'($urandom_range(0, 125));
    end else if (pick < 88) begin
      form = FORM_16;
      n    = ($urandom_range(0, 19) == 0) ? 64'($urandom_range(126, 300))
                                          : 64'($urandom_range(0, 12));
    end else begin
      // 64-bit form stays within the limit until the very end
      form = FORM_64;
      n    = 64'($urandom_range(0, 12));
      if (cur_limit <= 40 && $urandom_range(0, 2) == 0) n = 64'(cur_limit);
      if (n > 64'(cur_limit)) n = 64'(cur_limit);
    end
    send_frame($urandom_range(0, 9) < 6, 3'($urandom), op, 1'($urandom), form, n, 1'b1);
  endtask

  initial begin
    int          phase_start;
    int          pick;
    logic [31:0] next_limit;
    logic [63:0] n;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed frames at the reset limit
    send_frame(1'b1, 3'b000, OP_TEXT, 1'b0, FORM_SHORT, 64'd2, 1'b1);
    send_frame(1'b0, 3'b000, OP_BINARY, 1'b1, FORM_SHORT, 64'd1, 1'b1);
    send_frame(1'b0, 3'b000, OP_CONT, 1'b0, FORM_SHORT, 64'd0, 1'b1);
    send_frame(1'b1, 3'b000, OP_TEXT, 1'b0, FORM_SHORT, 64'd0, 1'b1);
    send_frame(1'b1, 3'b000, OP_CONT, 1'b1, FORM_16, 64'd1, 1'b1);
    send_frame(1'b1, 3'b000, OP_CONT, 1'b0, FORM_SHORT, 64'd1, 1'b1);
    send_frame(1'b1, 3'b000, OP_PING, 1'b0, FORM_SHORT, 64'd0, 1'b1);
    send_frame(1'b1, 3'b000, OP_PING, 1'b0, FORM_64, 64'd2, 1'b1);
    send_frame(1'b1, 3'b111, OP_RSVD_TOP, 1'b0, FORM_SHORT, 64'd1, 1'b1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) begin
        case (p)
          1:       next_limit = 32'h0000_0000;
          2:       next_limit = 32'hFFFF_FFFF;
          3:       next_limit = $urandom_range(1, 40);
          default: next_limit = $urandom;
        endcase
        // results done, then let the pipeline empty before the write
        wait_drained();
        repeat (4) @(posedge clk);
        write_limit(next_limit);
      end
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        random_frame();
        if ($urandom_range(0, 39) == 0) wait_drained();
      end
    end

    // one terminal frame: close with or without payload, or a length error
    pick = $urandom_range(0, 2);
    if (pick == 0) begin
      send_frame(1'b1, 3'($urandom), OP_CLOSE, 1'($urandom), FORM_SHORT, 64'd0, 1'b1);
    end else if (pick == 1) begin
      send_frame(1'b1, 3'($urandom), OP_CLOSE, 1'b1, FORM_16,
                 64'($urandom_range(1, 5)), 1'b1);
    end else begin
      n = {$urandom, $urandom};
      if (n <= 64'(cur_limit)) n = 64'(cur_limit) + 64'd1;
      send_frame(1'b1, 3'b000, OP_BINARY, 1'($urandom), FORM_64, n, 1'b0);
    end
    // stopped unit must swallow these silently
    repeat (12) send_byte(8'($urandom));

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_websocket_frame_deframer_unit: PASS");
    end else begin
      $display("tb_websocket_frame_deframer_unit: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/wsfd_pkg.sv
hw/rtl/wsfd_parser.sv
hw/rtl/websocket_frame_deframer_unit.sv
tb/deframer_checker.sv
tb/tb_websocket_frame_deframer_unit.sv
